[src/eep_pkg.sv]
// ----------------------------------------------------------------------------
// eep_pkg: shared types and constants of the expiring entry pool
// Item layouts, the stored entry layout and the request kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package eep_pkg;

   // Default number of slots in the pool
   localparam int POOL_DEPTH = 16;

   // Request kind codes
   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_DUMP = 2'd2;

   // One input item
   typedef struct packed {
      logic        [1:0]  kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic        [31:0] radius;
      logic signed [31:0] strength;
      logic        [31:0] life;
      logic signed [31:0] speed;
      logic        [31:0] elapsed;
   } req_type;

   // One result item
   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic        [31:0] out_radius;
      logic signed [31:0] out_strength;
      logic        [31:0] out_remaining;
      logic        [31:0] out_total;
      logic signed [31:0] out_speed;
      logic        [4:0]  live_count;
      logic               pool_empty;
      logic               last;
   } rsp_type;

   // One stored entry, Q16.16 throughout
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] radius;
      logic [31:0] strength;
      logic [31:0] remaining;
      logic [31:0] total;
      logic [31:0] speed;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   // Build a fresh entry from an add item; remaining and total both take the lifetime
   function automatic entry_type make_entry(input req_type r);
      entry_type e;
      e.x         = r.pos_x;
      e.y         = r.pos_y;
      e.z         = r.pos_z;
      e.radius    = r.radius;
      e.strength  = r.strength;
      e.remaining = r.life;
      e.total     = r.life;
      e.speed     = r.speed;
      return e;
   endfunction

endpackage

`default_nettype wire

[src/eep_if.sv]
// ----------------------------------------------------------------------------
// eep_if: valid/ready channels of the expiring entry pool
// Request channel carries one input item, response channel one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface eep_req_if;
   logic             valid;
   logic             ready;
   eep_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface eep_rsp_if;
   logic             valid;
   logic             ready;
   eep_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/eep_ram.sv]
// ----------------------------------------------------------------------------
// eep_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module eep_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write the addressed word, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[src/expiring_entry_pool.sv]
// An add with room writes in the cycle it is accepted; an add to a full
//   pool scans every slot in S_SCAN, then writes the least-life slot in S_PICK.
// A tick ages each live slot from the top down in S_TCHK; an expired entry that is
//   not the last live one is replaced by the last live entry through S_TMOV.
// A dump registers each result via S_DUMP, one per cycle while the output is free.
// Reset clears the live count and control; entry RAM contents stay undefined.
// ----------------------------------------------------------------------------
// expiring_entry_pool: fixed pool of timed entries
// Entries live in one RAM; add, tick and dump run read-modify-write over it.
// ----------------------------------------------------------------------------
`default_nettype none

module expiring_entry_pool #(
   parameter int POOL_DEPTH = eep_pkg::POOL_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   eep_req_if.sink   req_ch,
   eep_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(POOL_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_TCHK,
      S_TMOV,
      S_DUMP
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       live_ff, live_in;
   eep_pkg::req_type    item_ff, item_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic [31:0]         best_ff, best_in;
   logic [AW-1:0]       best_slot_ff, best_slot_in;
   eep_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   eep_pkg::entry_type  wr_data;
   logic [AW-1:0]       rd_addr;
   eep_pkg::entry_type  rd_entry;

   logic                accept;
   logic                rsp_free;
   logic [CW-1:0]       live_m1;
   logic [AW-1:0]       last_live;
   logic [CW+4:0]       live_wide;
   logic [AW-1:0]       scan_idx;

   eep_ram #(
      .WIDTH (eep_pkg::ENTRY_WIDTH),
      .DEPTH (POOL_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign live_m1      = live_ff - 1'b1;
   assign last_live    = live_m1[AW-1:0];
   assign live_wide    = {5'b0, live_ff};
   assign scan_idx     = scan_ff - 1'b1;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   // Next-state and RAM access control
   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      item_in      = item_ff;
      slot_in      = slot_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = rd_entry;
      rd_addr      = slot_ff;

      // Drop the result once it is taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_ch.data;
               unique case (req_ch.data.kind)
                  eep_pkg::KIND_ADD: begin
                     if (live_ff == FULL_CNT) begin
                        scan_in  = '0;
                        state_in = S_SCAN;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = live_ff[AW-1:0];
                        wr_data = eep_pkg::make_entry(req_ch.data);
                        live_in = live_ff + 1'b1;
                     end
                  end
                  eep_pkg::KIND_TICK: begin
                     if (live_ff != '0) begin
                        slot_in  = last_live;
                        rd_addr  = last_live;
                        state_in = S_TCHK;
                     end
                  end
                  eep_pkg::KIND_DUMP: begin
                     slot_in  = '0;
                     rd_addr  = '0;
                     state_in = S_DUMP;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Issue reads of every slot, compare the word read in the previous cycle
         S_SCAN: begin
            rd_addr = scan_ff;
            if (scan_ff != '0) begin
               if (scan_ff == AW'(1) || rd_entry.remaining < best_ff) begin
                  best_in      = rd_entry.remaining;
                  best_slot_in = scan_idx;
               end
            end
            if (scan_ff == LAST_SLOT) begin
               state_in = S_PICK;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         // Compare the last slot, overwrite the lowest slot with least life
         S_PICK: begin
            wr_en    = 1'b1;
            wr_addr  = (rd_entry.remaining < best_ff) ? LAST_SLOT : best_slot_ff;
            wr_data  = eep_pkg::make_entry(item_ff);
            state_in = S_IDLE;
         end

         // Age one slot; on expiry fetch the last live entry unless it is this one
         S_TCHK: begin
            if (rd_entry.remaining <= item_ff.elapsed) begin
               if (slot_ff == last_live) begin
                  live_in = live_m1;
                  if (slot_ff == '0) begin
                     state_in = S_IDLE;
                  end else begin
                     slot_in = slot_ff - 1'b1;
                     rd_addr = slot_ff - 1'b1;
                  end
               end else begin
                  rd_addr  = last_live;
                  state_in = S_TMOV;
               end
            end else begin
               wr_en             = 1'b1;
               wr_addr           = slot_ff;
               wr_data           = rd_entry;
               wr_data.remaining = rd_entry.remaining - item_ff.elapsed;
               if (slot_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in = slot_ff - 1'b1;
                  rd_addr = slot_ff - 1'b1;
               end
            end
         end

         // Move the last live entry into the freed slot
         S_TMOV: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff;
            wr_data = rd_entry;
            live_in = live_m1;
            if (slot_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               slot_in  = slot_ff - 1'b1;
               rd_addr  = slot_ff - 1'b1;
               state_in = S_TCHK;
            end
         end

         // List live entries in slot order, one per free output cycle
         S_DUMP: begin
            rd_addr = slot_ff;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (live_ff == '0) begin
                  rsp_in            = '0;
                  rsp_in.pool_empty = 1'b1;
                  rsp_in.last       = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  rsp_in.out_x         = rd_entry.x;
                  rsp_in.out_y         = rd_entry.y;
                  rsp_in.out_z         = rd_entry.z;
                  rsp_in.out_radius    = rd_entry.radius;
                  rsp_in.out_strength  = rd_entry.strength;
                  rsp_in.out_remaining = rd_entry.remaining;
                  rsp_in.out_total     = rd_entry.total;
                  rsp_in.out_speed     = rd_entry.speed;
                  rsp_in.live_count    = live_wide[4:0];
                  rsp_in.pool_empty    = 1'b0;
                  rsp_in.last          = (slot_ff == last_live);
                  if (slot_ff == last_live) begin
                     state_in = S_IDLE;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                     rd_addr = slot_ff + 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, counters and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      slot_ff      <= slot_in;
      scan_ff      <= scan_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      rsp_ff       <= rsp_in;
   end

   // Live count never exceeds the pool size
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= FULL_CNT)
      else $error("live count above pool depth");

   // An empty-pool result is always the final result of its dump
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.pool_empty |-> rsp_ff.last)
      else $error("empty result without last");

   // A moved entry always comes from a slot above the one being freed
   a_move_src: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TMOV |-> slot_ff < last_live)
      else $error("tick move from a slot not above the freed slot");

   // A dump never changes the live count
   a_dump_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |=> $stable(live_ff))
      else $error("live count changed during dump");

endmodule

`default_nettype wire

[sim/eep_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eep_checker: result checker for the expiring entry pool
// Watches both channels, keeps a shadow copy of the pool, predicts each
// dump listing and compares every result item field by field in order.
// ----------------------------------------------------------------------------

module eep_checker #(
   parameter int POOL_DEPTH = eep_pkg::POOL_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  eep_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  eep_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_rows
);

   // Shadow pool and the listing rows still owed by the block
   eep_pkg::entry_type slot_mem [POOL_DEPTH];
   int unsigned        live_n;
   eep_pkg::rsp_type   listing_q [$];

   // Store a new entry: append while there is room, else replace the
   // lowest slot holding the least remaining life
   function automatic void shadow_add(input eep_pkg::req_type item);
      eep_pkg::entry_type e;
      int unsigned        slot;
      logic [31:0]        least;
      e.x         = item.pos_x;
      e.y         = item.pos_y;
      e.z         = item.pos_z;
      e.radius    = item.radius;
      e.strength  = item.strength;
      e.remaining = item.life;
      e.total     = item.life;
      e.speed     = item.speed;
      if (live_n >= POOL_DEPTH) begin
         slot  = 0;
         least = slot_mem[0].remaining;
         for (int unsigned i = 1; i < POOL_DEPTH; i++) begin
            if (slot_mem[i].remaining < least) begin
               least = slot_mem[i].remaining;
               slot  = i;
            end
         end
      end else begin
         slot   = live_n;
         live_n = live_n + 1;
      end
      slot_mem[slot] = e;
   endfunction

   // Age every live entry from the top slot down; an expired entry is
   // replaced by the current last entry, which was already aged
   function automatic void shadow_tick(input logic [31:0] dt);
      int unsigned n;
      int unsigned i;
      n = live_n;
      i = n;
      while (i > 0) begin
         i = i - 1;
         if (slot_mem[i].remaining <= dt) begin
            slot_mem[i] = slot_mem[n - 1];
            n = n - 1;
         end else begin
            slot_mem[i].remaining = slot_mem[i].remaining - dt;
         end
      end
      live_n = n;
   endfunction

   // Queue the rows a dump must produce
   function automatic void predict_listing();
      eep_pkg::rsp_type row;
      row = '0;
      if (live_n == 0) begin
         row.pool_empty = 1'b1;
         row.last       = 1'b1;
         listing_q.push_back(row);
      end else begin
         for (int unsigned i = 0; i < live_n; i++) begin
            row.out_x         = slot_mem[i].x;
            row.out_y         = slot_mem[i].y;
            row.out_z         = slot_mem[i].z;
            row.out_radius    = slot_mem[i].radius;
            row.out_strength  = slot_mem[i].strength;
            row.out_remaining = slot_mem[i].remaining;
            row.out_total     = slot_mem[i].total;
            row.out_speed     = slot_mem[i].speed;
            row.live_count    = live_n[4:0];
            row.pool_empty    = 1'b0;
            row.last          = (i + 1 == live_n);
            listing_q.push_back(row);
         end
      end
   endfunction

   task automatic compare_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   // Match one result item against the oldest pending row
   task automatic check_row(input eep_pkg::rsp_type got);
      eep_pkg::rsp_type want;
      if (listing_q.size() == 0) begin
         $display("%0t: unexpected result item, expected none, actual %h", $time, got);
         mismatch_count = mismatch_count + 1;
      end else begin
         want = listing_q.pop_front();
         compare_field("out_x",         want.out_x,         got.out_x);
         compare_field("out_y",         want.out_y,         got.out_y);
         compare_field("out_z",         want.out_z,         got.out_z);
         compare_field("out_radius",    want.out_radius,    got.out_radius);
         compare_field("out_strength",  want.out_strength,  got.out_strength);
         compare_field("out_remaining", want.out_remaining, got.out_remaining);
         compare_field("out_total",     want.out_total,     got.out_total);
         compare_field("out_speed",     want.out_speed,     got.out_speed);
         compare_field("live_count",    32'(want.live_count), 32'(got.live_count));
         compare_field("pool_empty",    32'(want.pool_empty), 32'(got.pool_empty));
         compare_field("last",          32'(want.last),       32'(got.last));
      end
   endtask

   // Check results first; a dump never answers in its own accept cycle
   always @(posedge clock) begin
      if (reset) begin
         live_n = 0;
         listing_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_row(rsp_data);
         end
         if (req_valid && req_ready) begin
            case (req_data.kind)
               eep_pkg::KIND_ADD:  shadow_add(req_data);
               eep_pkg::KIND_TICK: shadow_tick(req_data.elapsed);
               eep_pkg::KIND_DUMP: predict_listing();
               default:            ;
            endcase
         end
      end
      pending_rows = listing_q.size();
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the expiring entry pool
// Drives directed and random add, tick, dump and unused-kind items with random
// gaps and result stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_top;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 330;

   logic clock;
   logic reset;
   logic steady;
   int   mismatch_count;
   int   pending_rows;

   eep_req_if req_ch ();
   eep_rsp_if rsp_ch ();

   expiring_entry_pool #(.POOL_DEPTH(eep_pkg::POOL_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   eep_checker #(.POOL_DEPTH(eep_pkg::POOL_DEPTH)) pool_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_data       (req_ch.data),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_data       (rsp_ch.data),
      .mismatch_count (mismatch_count),
      .pending_rows   (pending_rows)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // Stall the result side now and then, except in the steady stretch
   always @(negedge clock) begin
      rsp_ch.ready = steady || ($urandom_range(99) >= 12);
   end

   function automatic eep_pkg::req_type random_req(input logic [1:0] kind);
      eep_pkg::req_type r;
      r.kind     = kind;
      r.pos_x    = $urandom;
      r.pos_y    = $urandom;
      r.pos_z    = $urandom;
      r.radius   = $urandom;
      r.strength = $urandom;
      r.life     = $urandom;
      r.speed    = $urandom;
      r.elapsed  = $urandom;
      return r;
   endfunction

   function automatic eep_pkg::req_type make_req(input logic [1:0] kind,
                                        input logic [31:0] x, y, z, radius, strength,
                                        input logic [31:0] life, speed, elapsed);
      eep_pkg::req_type r;
      r.kind     = kind;
      r.pos_x    = x;
      r.pos_y    = y;
      r.pos_z    = z;
      r.radius   = radius;
      r.strength = strength;
      r.life     = life;
      r.speed    = speed;
      r.elapsed  = elapsed;
      return r;
   endfunction

   // Present one item at a falling edge and hold it until accepted
   task automatic send_item(input eep_pkg::req_type item);
      if (!steady && $urandom_range(99) < 12) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(2)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.data  = item;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      eep_pkg::req_type r;
      int               sent;
      int               pick;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      steady       = 1'b0;
      reset        = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty pool lists a single empty marker
      send_item(random_req(eep_pkg::KIND_DUMP));

      // Extreme field values, one entry born with zero life
      send_item(make_req(eep_pkg::KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                         32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000,
                         32'h0000_0000));
      send_item(make_req(eep_pkg::KIND_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                         32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff,
                         32'hffff_ffff));
      send_item(random_req(eep_pkg::KIND_DUMP));

      // Zero step still expires the zero-life entry
      send_item(make_req(eep_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0, '0, 32'h0000_0000));
      send_item(random_req(eep_pkg::KIND_DUMP));

      // Unused kind must leave the pool alone
      send_item(random_req(KIND_UNUSED));
      send_item(random_req(eep_pkg::KIND_DUMP));

      // Fill the pool with repeating lives so the replacement sees ties
      for (int k = 0; k < eep_pkg::POOL_DEPTH - 1; k++) begin
         r      = random_req(eep_pkg::KIND_ADD);
         r.life = ((k % 3) + 1) << 16;
         send_item(r);
      end
      r      = random_req(eep_pkg::KIND_ADD);
      r.life = 32'h0000_8000;
      send_item(r);
      send_item(random_req(eep_pkg::KIND_DUMP));

      // Largest step clears everything
      send_item(make_req(eep_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0, '0, 32'hffff_ffff));
      send_item(random_req(eep_pkg::KIND_DUMP));

      // Random mix; lives and steps mostly comparable so entries churn
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = (sent >= 120 && sent < 220);
         pick   = $urandom_range(99);
         if (pick < 48) begin
            r = random_req(eep_pkg::KIND_ADD);
            case ($urandom_range(9)) inside
               0:       ;
               [1:2]:   r.life = $urandom_range(3) << 16;
               default: r.life = $urandom_range(32'h0006_0000);
            endcase
         end else if (pick < 73) begin
            r = random_req(eep_pkg::KIND_TICK);
            case ($urandom_range(9))
               0:       ;
               1:       r.elapsed = '0;
               default: r.elapsed = $urandom_range(32'h0003_0000);
            endcase
         end else if (pick < 95) begin
            r = random_req(eep_pkg::KIND_DUMP);
         end else begin
            r = random_req(KIND_UNUSED);
         end
         send_item(r);
         if (r.kind != KIND_UNUSED) begin
            sent = sent + 1;
         end
      end
      steady = 1'b0;

      // Close with a dump so the final state is checked
      send_item(random_req(eep_pkg::KIND_DUMP));
      @(negedge clock);
      req_ch.valid = 1'b0;

      // Drain, then allow a full-pool scan worth of cycles
      while (pending_rows != 0) @(negedge clock);
      repeat (2 * eep_pkg::POOL_DEPTH + 8) @(negedge clock);

      if (mismatch_count == 0 && pending_rows == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
